FILE: hw/rtl/src_pkg.sv
// shared types and constants for the spline response curve unit
// no dependencies; imported by every other file of the block
package src_pkg;

	localparam int NP  = 7;   // point registers
	localparam int XW  = 18;  // point x, unsigned q10.8
	localparam int YW  = 19;  // point y, signed q10.8
	localparam int PTW = 37;  // packed point register
	localparam int KW  = 19;  // grid index
	localparam int PW  = 27;  // grid position in 1/(256*grid) units
	localparam int NW  = 45;  // divider dividend magnitude
	localparam int DW  = 28;  // divider divisor
	localparam int TW  = 17;  // spline parameter, q16 up to one
	localparam int WW  = 20;  // doubled basis weight, q16
	localparam int AW  = 42;  // weighted sum accumulator
	localparam int GVW = 22;  // grid value, signed q8
	localparam int OW  = 19;  // output value
	localparam int BW  = 24;  // stream data width

	localparam logic [2:0] REG_COUNT  = 3'd0;
	localparam logic [2:0] REG_POINT0 = 3'd1;

	localparam logic [2:0]     COUNT_RST  = 3'd2;
	localparam logic [PTW-1:0] POINT0_RST = 37'd5368714240;
	localparam logic [PTW-1:0] POINT1_RST = 37'd10737428480;

	localparam logic [TW-1:0] T_ONE = 17'd65536;

	typedef struct packed {
		logic load;
		logic sort;
		logic clr_res;
		logic setup;
		logic seg;
		logic div_start;
		logic t_load;
		logic sq;
		logic cube;
		logic wgt;
		logic mac;
		logic gres;
		logic gsave;
		logic blend;
		logic out_load;
	} src_cmd_t;

	typedef struct packed {
		logic n_zero;
		logic f_zero;
		logic ramp;
		logic t_zero;
		logic div_busy;
		logic mac_last;
		logic second;
	} src_stat_t;

endpackage

FILE: hw/rtl/src_div.sv
// restoring divider, one quotient bit per cycle, unsigned operands
// depends on src_pkg for widths
module src_div
	import src_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          busy,
	output logic [NW-1:0] quo,
	output logic          rem_nz
);

	localparam int CW = $clog2(NW + 1);

	logic [CW-1:0] cnt_q;
	logic [NW-1:0] quo_q;
	logic [DW:0]   rem_q;
	logic [DW-1:0] den_q;
	logic [DW:0]   rem_sh;
	logic          ge;

	assign rem_sh = {rem_q[DW-1:0], quo_q[NW-1]};
	assign ge     = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(NW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[NW-2:0], ge};
			rem_q <= ge ? rem_sh - {1'b0, den_q} : rem_sh;
		end
	end

	assign busy   = cnt_q != '0;
	assign quo    = quo_q;
	assign rem_nz = rem_q != '0;

endmodule

FILE: hw/rtl/src_dp.sv
// datapath: config registers, point sort, grid evaluation, blend and output register
// depends on src_pkg and src_div
module src_dp
	import src_pkg::*;
#(
	parameter int GRID_STEPS = 16,
	parameter int MAX_POINTS = 7
)(
	input  logic            clk,
	input  logic            arst_n,
	input  src_cmd_t        cmd,
	output src_stat_t       stat,
	input  logic [OW-1:0]   x_in,
	output logic [OW-1:0]   value,
	input  logic            cfg_we,
	input  logic [2:0]      cfg_index,
	input  logic [PTW-1:0]  cfg_data
);

	// configuration
	logic [2:0]     cnt_q;
	logic [PTW-1:0] pt_q [NP];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= COUNT_RST;
			pt_q[0] <= POINT0_RST;
			pt_q[1] <= POINT1_RST;
			for (int i = 2; i < NP; i++) pt_q[i] <= '0;
		end else if (cfg_we) begin
			if (cfg_index == REG_COUNT) begin
				cnt_q <= cfg_data[2:0];
			end else begin
				pt_q[cfg_index - REG_POINT0] <= cfg_data;
			end
		end
	end

	// input split
	logic              neg_q;
	logic [KW-1:0]     k1_q;
	logic [7:0]        f_q;
	logic signed [OW-1:0] xs_in;
	logic [OW-1:0]     mag_c;
	logic [PW-1:0]     p_c;

	assign xs_in = $signed(x_in);
	assign mag_c = xs_in[OW-1] ? OW'(-xs_in) : x_in;
	assign p_c   = PW'(mag_c) * PW'(GRID_STEPS);

	// stable sort by rank
	logic [XW-1:0]        px [NP];
	logic signed [YW-1:0] py [NP];
	logic [2:0]           rank [NP];
	logic [2:0]           n_c;

	assign n_c = (cnt_q > 3'(MAX_POINTS)) ? 3'(MAX_POINTS) : cnt_q;

	always_comb begin
		for (int i = 0; i < NP; i++) begin
			px[i] = pt_q[i][XW-1:0];
			py[i] = $signed(pt_q[i][PTW-1:XW]);
		end
		for (int i = 0; i < NP; i++) begin
			rank[i] = '0;
			for (int j = 0; j < NP; j++) begin
				if (3'(j) < n_c && j != i) begin
					if ((j < i && px[j] <= px[i]) || (j > i && px[j] < px[i]))
						rank[i] = rank[i] + 3'd1;
				end
			end
		end
	end

	logic [XW-1:0]        xs_q [NP];
	logic signed [YW-1:0] ys_q [NP];
	logic [2:0]           n_q;
	logic                 sec_q;

	// grid setup
	logic [KW-1:0] k_c, size_c, kc_c, k0_c;
	logic [XW-1:0] last_x;
	logic [PW-1:0] pos_c;
	logic [KW-1:0] kc_q, k0_q;
	logic [PW-1:0] pos_q;
	logic          ramp_q;

	assign k_c    = sec_q ? k1_q + 1'b1 : k1_q;
	assign last_x = xs_q[n_q - 3'd1];
	assign size_c = KW'(GRID_STEPS) * (KW'(last_x >> 8) + 1'b1);
	assign kc_c   = (k_c >= size_c) ? size_c - 1'b1 : k_c;
	assign k0_c   = KW'((PW'(xs_q[0]) * PW'(GRID_STEPS)) >> 8);
	assign pos_c  = PW'(xs_q[0]) * PW'(GRID_STEPS) + (PW'(kc_c - k0_c) << 8);

	// segment search
	logic [PW-1:0]        gx [NP];
	logic [2:0]           j_c, nm1, b_i, c_i, d_i;
	logic [3:0]           d4;
	logic [XW-1:0]        bx_c, cx_c;
	logic [PW-1:0]        gbx;
	logic signed [YW-1:0] ay_q, by_q, cy_q, dy_q;
	logic [PW-1:0]        num_q, den_q;
	logic                 tz_q;

	always_comb begin
		for (int i = 0; i < NP; i++) gx[i] = PW'(xs_q[i]) * PW'(GRID_STEPS);
		j_c = n_q;
		for (int i = NP - 1; i >= 1; i--) begin
			if (3'(i) < n_q && gx[i] > pos_q) j_c = 3'(i);
		end
	end

	assign nm1  = n_q - 3'd1;
	assign b_i  = j_c - 3'd1;
	assign c_i  = (j_c > nm1) ? nm1 : j_c;
	assign d4   = {1'b0, j_c} + 4'd1;
	assign d_i  = (d4 > {1'b0, nm1}) ? nm1 : d4[2:0];
	assign bx_c = xs_q[b_i];
	assign cx_c = xs_q[c_i];
	assign gbx  = PW'(bx_c) * PW'(GRID_STEPS);

	// divider operands
	logic signed [KW:0]       kcs;
	logic signed [YW+KW:0]    rprod;
	logic signed [NW:0]       n_s;
	logic [NW-1:0]            dmag;
	logic [DW-1:0]            dden;
	logic                     dneg_q;
	logic                     div_busy;
	logic [NW-1:0]            quo;
	logic                     rem_nz;
	logic signed [NW+1:0]     q_s;

	assign kcs   = $signed({1'b0, kc_q});
	assign rprod = ys_q[0] * kcs;
	assign n_s   = ramp_q ? ((NW+1)'(rprod) <<< 1) + $signed((NW+1)'(k0_q))
	                      : $signed(((NW+1)'(num_q) << 17) + (NW+1)'(den_q));
	assign dmag  = n_s[NW] ? NW'(-n_s) : NW'(n_s);
	assign dden  = ramp_q ? (DW'(k0_q) << 1) : (DW'(den_q) << 1);

	src_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (dmag),
		.den    (dden),
		.busy   (div_busy),
		.quo    (quo),
		.rem_nz (rem_nz)
	);

	assign q_s = dneg_q ? -$signed({2'b00, quo} + (NW+2)'(rem_nz)) : $signed({2'b00, quo});

	// basis weights
	logic [TW-1:0]          t_q;
	logic [2*TW-1:0]        t2_q;
	logic [3*TW-1:0]        t3_q;
	logic signed [53:0]     e1, e2, e3, wa_c, wb_c, wc_c, wd_c;
	logic signed [WW-1:0]   w_q [4];
	logic signed [YW-1:0]   yv [4];
	logic [1:0]             mi_q;
	logic signed [AW-1:0]   acc_q;
	logic signed [YW+WW-1:0] mprod;

	assign e1   = $signed(54'(t_q));
	assign e2   = $signed(54'(t2_q));
	assign e3   = $signed(54'(t3_q));
	assign wa_c = -e3 + (e2 <<< 17) - (e1 <<< 32) + (54'sd1 <<< 31);
	assign wb_c = 54'sd3 * e3 - 54'sd5 * (e2 <<< 16) + (54'sd1 <<< 49) + (54'sd1 <<< 31);
	assign wc_c = -(54'sd3 * e3) + (e2 <<< 18) + (e1 <<< 32) + (54'sd1 <<< 31);
	assign wd_c = e3 - (e2 <<< 16) + (54'sd1 <<< 31);

	assign yv[0] = ay_q;
	assign yv[1] = by_q;
	assign yv[2] = cy_q;
	assign yv[3] = dy_q;
	assign mprod = yv[mi_q] * w_q[mi_q];

	// grid values and blend
	logic signed [GVW-1:0] grid_q, first_q, second_q;
	logic signed [GVW:0]   dlt;
	logic signed [GVW+9:0] bprod;
	logic signed [GVW+1:0] v_c, vn_c;
	logic [OW-1:0]         res_q, out_q;
	logic signed [AW-1:0]  acc_r;

	assign acc_r = acc_q + AW'(65536);
	assign dlt   = {second_q[GVW-1], second_q} - {first_q[GVW-1], first_q};
	assign bprod = dlt * $signed({1'b0, f_q});
	assign v_c   = (GVW+2)'(first_q) + (GVW+2)'((bprod + (GVW+10)'(128)) >>> 8);
	assign vn_c  = neg_q ? -v_c : v_c;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q <= xs_in[OW-1];
			k1_q  <= p_c[PW-1:8];
			f_q   <= p_c[7:0];
		end
		if (cmd.sort) begin
			n_q <= n_c;
			for (int i = 0; i < NP; i++) begin
				if (3'(i) < n_c) begin
					xs_q[rank[i]] <= px[i];
					ys_q[rank[i]] <= py[i];
				end
			end
		end
		if (cmd.setup) begin
			kc_q   <= kc_c;
			k0_q   <= k0_c;
			ramp_q <= kc_c < k0_c;
			pos_q  <= pos_c;
		end
		if (cmd.seg) begin
			ay_q  <= (j_c >= 3'd2) ? ys_q[j_c - 3'd2] : '0;
			by_q  <= ys_q[b_i];
			cy_q  <= ys_q[c_i];
			dy_q  <= ys_q[d_i];
			tz_q  <= cx_c <= bx_c;
			num_q <= (pos_q > gbx) ? pos_q - gbx : '0;
			den_q <= PW'(cx_c - bx_c) * PW'(GRID_STEPS);
		end
		if (cmd.div_start) dneg_q <= n_s[NW];
		if (cmd.t_load) begin
			if (tz_q) t_q <= '0;
			else t_q <= (q_s > $signed((NW+2)'(T_ONE))) ? T_ONE : q_s[TW-1:0];
		end
		if (cmd.sq) t2_q <= t_q * t_q;
		if (cmd.cube) t3_q <= t2_q * (2*TW)'(t_q);
		if (cmd.wgt) begin
			w_q[0] <= wa_c[32+WW-1:32];
			w_q[1] <= wb_c[32+WW-1:32];
			w_q[2] <= wc_c[32+WW-1:32];
			w_q[3] <= wd_c[32+WW-1:32];
			acc_q  <= '0;
			mi_q   <= '0;
		end
		if (cmd.mac) begin
			acc_q <= acc_q + AW'(mprod);
			mi_q  <= mi_q + 2'd1;
		end
		if (cmd.gres) grid_q <= ramp_q ? q_s[GVW-1:0] : acc_r[17+GVW-1:17];
		if (cmd.gsave) begin
			if (!sec_q) first_q <= grid_q;
			second_q <= grid_q;
		end
		if (cmd.clr_res) res_q <= '0;
		if (cmd.blend) begin
			if (vn_c > $signed((GVW+2)'(262143))) res_q <= OW'(262143);
			else if (vn_c < -$signed((GVW+2)'(262144))) res_q <= OW'(262144);
			else res_q <= vn_c[OW-1:0];
		end
		if (cmd.out_load) out_q <= res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sec_q <= 1'b0;
		else if (cmd.load) sec_q <= 1'b0;
		else if (cmd.gsave) sec_q <= 1'b1;
	end

	assign value         = out_q;
	assign stat.n_zero   = n_q == '0;
	assign stat.f_zero   = f_q == '0;
	assign stat.ramp     = ramp_q;
	assign stat.t_zero   = tz_q;
	assign stat.div_busy = div_busy;
	assign stat.mac_last = mi_q == 2'd3;
	assign stat.second   = sec_q;

endmodule

FILE: hw/rtl/src_ctrl.sv
// controller: sequences sort, up to two grid evaluations, blend and the output handshake
// depends on src_pkg
module src_ctrl
	import src_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	output logic      m_tvalid,
	input  logic      m_tready,
	output src_cmd_t  cmd,
	input  src_stat_t stat
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_SORT  = 4'd1;
	localparam logic [3:0] S_CHK   = 4'd2;
	localparam logic [3:0] S_SETUP = 4'd3;
	localparam logic [3:0] S_SEG   = 4'd4;
	localparam logic [3:0] S_TDIV  = 4'd5;
	localparam logic [3:0] S_DIV   = 4'd6;
	localparam logic [3:0] S_TLOAD = 4'd7;
	localparam logic [3:0] S_SQ    = 4'd8;
	localparam logic [3:0] S_CUBE  = 4'd9;
	localparam logic [3:0] S_WGT   = 4'd10;
	localparam logic [3:0] S_MAC   = 4'd11;
	localparam logic [3:0] S_GRES  = 4'd12;
	localparam logic [3:0] S_GSAVE = 4'd13;
	localparam logic [3:0] S_BLEND = 4'd14;
	localparam logic [3:0] S_OUT   = 4'd15;

	logic [3:0] state_q, state_d;
	logic       mvalid_q;
	logic       out_free;

	assign s_tready = state_q == S_IDLE;
	assign m_tvalid = mvalid_q;
	assign out_free = !mvalid_q || m_tready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = S_SORT;
				end
			end
			S_SORT: begin
				cmd.sort = 1'b1;
				state_d  = S_CHK;
			end
			S_CHK: begin
				if (stat.n_zero) begin
					cmd.clr_res = 1'b1;
					state_d     = S_OUT;
				end else begin
					state_d = S_SETUP;
				end
			end
			S_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = S_SEG;
			end
			S_SEG: begin
				if (stat.ramp) begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV;
				end else begin
					cmd.seg = 1'b1;
					state_d = S_TDIV;
				end
			end
			S_TDIV: begin
				if (stat.t_zero) begin
					state_d = S_TLOAD;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV;
				end
			end
			S_DIV: begin
				if (!stat.div_busy) state_d = stat.ramp ? S_GRES : S_TLOAD;
			end
			S_TLOAD: begin
				cmd.t_load = 1'b1;
				state_d    = S_SQ;
			end
			S_SQ: begin
				cmd.sq  = 1'b1;
				state_d = S_CUBE;
			end
			S_CUBE: begin
				cmd.cube = 1'b1;
				state_d  = S_WGT;
			end
			S_WGT: begin
				cmd.wgt = 1'b1;
				state_d = S_MAC;
			end
			S_MAC: begin
				cmd.mac = 1'b1;
				if (stat.mac_last) state_d = S_GRES;
			end
			S_GRES: begin
				cmd.gres = 1'b1;
				state_d  = S_GSAVE;
			end
			S_GSAVE: begin
				cmd.gsave = 1'b1;
				// second grid point only when the blend fraction is nonzero
				state_d = (!stat.second && !stat.f_zero) ? S_SETUP : S_BLEND;
			end
			S_BLEND: begin
				cmd.blend = 1'b1;
				state_d   = S_OUT;
			end
			S_OUT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			mvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) mvalid_q <= 1'b1;
			else if (m_tready) mvalid_q <= 1'b0;
		end
	end

`ifndef SYNTH
	a_accept_sorts: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q == S_SORT)
		else $error("accepted transfer did not start the sort");
	a_out_loads: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_OUT && out_free |=> m_tvalid && state_q == S_IDLE)
		else $error("result not presented after output step");
	a_div_runs: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> stat.div_busy && state_q == S_DIV)
		else $error("divider did not start");
`endif

endmodule

FILE: hw/rtl/spline_response_curve_unit.sv
// Sign-symmetric spline response curve with up to seven control points.
//
// Slave stream s_* carries one input transfer: tdata[18:0] = x_in (signed q10.8),
// upper bits zero. Master stream m_* returns one result per input:
// tdata[18:0] = value (signed q10.8, saturated), upper bits zero.
// Config port: cfg_we with cfg_index 0 writes point_count, 1..7 write point_0..6
// (x in bits 17..0, y in bits 36..18); write only while the block is idle.
// One item at a time: s_tready is high only when no item is in work.
// A second grid point is evaluated only when the blend fraction is nonzero; each
// grid point takes a setup step and then either one pass of the bit-serial divider
// (ramp below the first point) or a divider pass for the spline parameter, weights
// and a four-step multiply-add. A zero point count skips evaluation and gives zero.
// The result sits in an output register; a stalled receiver holds the block in
// its output step until m_tready. Reset (arst_n low) drops m_tvalid, returns the
// controller to idle and loads the default points (20,80) and (40,160), count 2.
// Depends on src_pkg, src_ctrl, src_dp, src_div.
module spline_response_curve_unit
	import src_pkg::*;
#(
	parameter int GRID_STEPS = 16,
	parameter int MAX_POINTS = 7
)(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  logic [BW-1:0]  s_tdata,   // [18:0] x_in
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [BW-1:0]  m_tdata,   // [18:0] value
	input  logic           cfg_we,
	input  logic [2:0]     cfg_index,
	input  logic [PTW-1:0] cfg_data
);

	src_cmd_t      cmd;
	src_stat_t     stat;
	logic [OW-1:0] value;

	src_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.stat     (stat)
	);

	src_dp #(
		.GRID_STEPS (GRID_STEPS),
		.MAX_POINTS (MAX_POINTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.x_in      (s_tdata[OW-1:0]),
		.value     (value),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	assign m_tdata = {{(BW-OW){1'b0}}, value};

endmodule
